FILE: sv/kwpf_pkg.sv
// ----------------------------------------------------------------------------
// kwpf_pkg: keypad word prefix filter shared types and constants
// Payload structs, letter-to-key group table and fixed field widths.
// ----------------------------------------------------------------------------
package kwpf_pkg;

  localparam int unsigned MAX_LETTERS  = 8;
  localparam int unsigned LETTER_W     = 5;
  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned INDEX_W      = 11;
  localparam int unsigned COUNT_W      = 12;
  localparam int unsigned NUM_DIGITS   = 10;
  localparam int unsigned QLEN_W       = 4;
  localparam int unsigned CFG_DATA_W   = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [DIGIT_W-1:0] NO_GROUP  = 4'd15;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_DIGITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUERY_LENGTH = 2'd1;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [NUM_DIGITS-1:0] digit_mask_t;

  typedef struct packed {
    logic                first_word;
    logic [INDEX_W-1:0]  word_index;
    letter_t             letter_0;
    letter_t             letter_1;
    letter_t             letter_2;
    letter_t             letter_3;
    letter_t             letter_4;
    letter_t             letter_5;
    letter_t             letter_6;
    letter_t             letter_7;
  } kwpf_in_t;

  typedef struct packed {
    logic                matched;
    logic [INDEX_W-1:0]  match_index;
    logic [COUNT_W-1:0]  match_total;
    digit_mask_t         next_digit_mask;
  } kwpf_out_t;

  // result of the compare stage handed to the accumulator
  typedef struct packed {
    logic        matched;
    digit_mask_t next_bit;
  } kwpf_match_t;

  // key group of a letter code; NO_GROUP for end marker and codes past z
  function automatic logic [DIGIT_W-1:0] letter_group(input letter_t code);
    logic [DIGIT_W-1:0] g;
    case (code) inside
      [5'd1:5'd2]:   g = 4'd0;
      [5'd3:5'd4]:   g = 4'd1;
      [5'd5:5'd6]:   g = 4'd2;
      [5'd7:5'd9]:   g = 4'd3;
      [5'd10:5'd13]: g = 4'd4;
      [5'd14:5'd16]: g = 4'd5;
      [5'd17:5'd18]: g = 4'd6;
      5'd19:         g = 4'd7;
      [5'd20:5'd21]: g = 4'd8;
      [5'd22:5'd26]: g = 4'd9;
      default:       g = NO_GROUP;
    endcase
    return g;
  endfunction

endpackage

FILE: sv/kwpf_match.sv
// ----------------------------------------------------------------------------
// kwpf_match: word against typed key sequence compare
// Parallel per-position group compare and next-key one-hot select.
// ----------------------------------------------------------------------------
module kwpf_match (
  input  kwpf_pkg::kwpf_in_t                                     word,
  input  logic [kwpf_pkg::CFG_DATA_W-1:0]                        query_digits,
  input  logic [kwpf_pkg::QLEN_W-1:0]                            query_length,
  output kwpf_pkg::kwpf_match_t                                  result
);
  import kwpf_pkg::*;

  letter_t                 letters [MAX_LETTERS];
  logic [MAX_LETTERS-1:0]  in_word;
  logic [MAX_LETTERS-1:0]  fit;
  logic [DIGIT_W-1:0]      grp [MAX_LETTERS];
  digit_mask_t             next_bit;

  assign letters[0] = word.letter_0;
  assign letters[1] = word.letter_1;
  assign letters[2] = word.letter_2;
  assign letters[3] = word.letter_3;
  assign letters[4] = word.letter_4;
  assign letters[5] = word.letter_5;
  assign letters[6] = word.letter_6;
  assign letters[7] = word.letter_7;

  always_comb begin
    logic alive;
    next_bit = '0;
    alive    = 1'b1;
    for (int p = 0; p < MAX_LETTERS; p++) begin
      grp[p] = letter_group(letters[p]);
      // position lies inside the word when no end marker at or before it
      alive      = alive && (letters[p] != '0);
      in_word[p] = alive;
      fit[p] = (QLEN_W'(p) >= query_length) ||
               (in_word[p] && (grp[p] == query_digits[p*DIGIT_W +: DIGIT_W]));
      if ((query_length == QLEN_W'(p)) && in_word[p] && (grp[p] != NO_GROUP)) begin
        next_bit = next_bit | (digit_mask_t'(1) << grp[p]);
      end
    end
  end

  // a query longer than a word can be never matches
  assign result.matched  = (&fit) && (query_length <= QLEN_W'(MAX_LETTERS));
  assign result.next_bit = next_bit;

endmodule

FILE: sv/kwpf_accum.sv
// ----------------------------------------------------------------------------
// kwpf_accum: match count, next-key mask and result register
// Saturating counter and OR mask, cleared on a first word, feeding the output.
// ----------------------------------------------------------------------------
module kwpf_accum (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,
  input  logic                              first_word,
  input  logic [kwpf_pkg::INDEX_W-1:0]      word_index,
  input  kwpf_pkg::kwpf_match_t             match,
  output logic                              stage_ready,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kwpf_pkg::kwpf_out_t               out_data
);
  import kwpf_pkg::*;

  logic [COUNT_W-1:0] count_r, count_nxt, count_base;
  digit_mask_t        mask_r, mask_nxt, mask_base;
  logic               out_valid_r, out_valid_nxt;
  kwpf_out_t          out_data_r, out_data_nxt;

  assign stage_ready = !out_valid_r || out_ready;

  always_comb begin
    count_base = first_word ? '0 : count_r;
    mask_base  = first_word ? '0 : mask_r;
    count_nxt  = count_r;
    mask_nxt   = mask_r;
    if (load) begin
      count_nxt = (match.matched && (count_base != COUNT_MAX)) ?
                  count_base + COUNT_W'(1) : count_base;
      mask_nxt  = match.matched ? (mask_base | match.next_bit) : mask_base;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt                = 1'b1;
      out_data_nxt.matched         = match.matched;
      out_data_nxt.match_index     = match.matched ? word_index : '0;
      out_data_nxt.match_total     = count_nxt;
      out_data_nxt.next_digit_mask = mask_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // within a search the mask only gains bits
  a_mask_grows: assert property (@(posedge clk) disable iff (!rst_n)
    load && !first_word |=> (($past(mask_r) & ~mask_r) == '0))
    else $error("next-key mask lost a bit within a search");

  // within a search the count never goes down
  a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
    load && !first_word |=> (count_r >= $past(count_r)))
    else $error("match count decreased within a search");

  // shown result agrees with the internal state it was loaded from
  a_out_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (out_data_r.match_total == count_r) &&
             (out_data_r.next_digit_mask == mask_r))
    else $error("result register out of step with accumulators");

  // a miss never carries an index
  a_miss_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.matched |-> (out_data_r.match_index == '0))
    else $error("unmatched result carries an index");
`endif

endmodule

FILE: sv/keypad_word_prefix_filter_unit.sv
// ----------------------------------------------------------------------------
// keypad_word_prefix_filter_unit: keypad predictive text word filter
// Streams dictionary words against typed keys, a word a cycle unless stalled.
// ----------------------------------------------------------------------------
// usage:
//   cfg port: write query_digits (index 0) and query_length (index 1) while
//   the block is idle; writes to other indexes are dropped
//   in channel: one dictionary word per transfer, first_word set on the
//   first word of a search clears the match count and next-key mask
//   out channel: one result per word: matched flag, index (zero on a miss),
//   running match count (saturates at 4095) and next-key mask
// path: an accepted word passes the input register, then the result register
//   after the compare and accumulate logic, where its result becomes valid
// throughput: one word per cycle unless stalled; the only carried state is
//   the counter and the OR mask, both updated when the result register loads
// reset: synchronous, active low; clears both queries, count, mask and the
//   valid flags of both stages
// stall: a held result keeps its value; the input register still takes one
//   more word, then in_ready drops until the result is taken
// ----------------------------------------------------------------------------
module keypad_word_prefix_filter_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  kwpf_pkg::kwpf_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output kwpf_pkg::kwpf_out_t               out_data,
  input  logic                              cfg_wr_en,
  input  logic [kwpf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [kwpf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import kwpf_pkg::*;

  // query registers
  logic [CFG_DATA_W-1:0] query_digits_r;
  logic [QLEN_W-1:0]     query_length_r;

  // input stage
  logic      s1_valid_r, s1_valid_nxt;
  kwpf_in_t  s1_data_r;
  logic      s1_advance;
  logic      stage_ready;

  kwpf_match_t match;

  // config writes, only the two defined indexes land
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_digits_r <= '0;
      query_length_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_QUERY_DIGITS: query_digits_r <= cfg_wdata;
        CFG_QUERY_LENGTH: query_length_r <= cfg_wdata[QLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register moves forward whenever the result register can take it
  assign s1_advance = s1_valid_r && stage_ready;
  assign in_ready   = !s1_valid_r || stage_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_advance;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
  end

  // per-position group compare
  kwpf_match u_match (
    .word         (s1_data_r),
    .query_digits (query_digits_r),
    .query_length (query_length_r),
    .result       (match)
  );

  // count, mask and result register
  kwpf_accum u_accum (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (s1_advance),
    .first_word  (s1_data_r.first_word),
    .word_index  (s1_data_r.word_index),
    .match       (match),
    .stage_ready (stage_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: keypad word prefix filter, self-checking
// Streams dictionary words through the filter under several typed key
// sequences and compares every result against a cycle-free model of the
// key groups, the running match count and the next-key mask. Directed
// words cover letter code extremes, word end markers, codes past z, bad
// digits and long queries. Random words are mostly built to fit the
// query. Both channels idle at random and the receiver holds off twice for
// a long stretch while words keep coming.
// ----------------------------------------------------------------------------
module testbench;
  import kwpf_pkg::*;

  // write port indexes that the block has no register for
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned STALL_LIMIT    = 3000;
  localparam int unsigned IDLE_PERCENT   = 14;
  localparam int unsigned MAX_REPORTS    = 10;

  // letters of one word, letter p in lt[p]
  typedef logic [MAX_LETTERS-1:0][LETTER_W-1:0] spelling_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  kwpf_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  kwpf_out_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_QUERY_DIGITS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // model copy of the query registers and the carried state
  logic [CFG_DATA_W-1:0] q_digits  = '0;
  logic [QLEN_W-1:0]     q_len     = '0;
  logic [COUNT_W-1:0]    tally     = '0;
  digit_mask_t           next_keys = '0;

  kwpf_out_t pending_verdicts[$];

  // steady: no random idling on either side
  logic        steady        = 1'b0;
  int unsigned hold_requests = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;
  int unsigned idle_cycles   = 0;

  int unsigned fault_count   = 0;
  int unsigned items_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned matches_seen  = 0;
  int unsigned settings_used = 1;

  always #2 clk = ~clk;

  keypad_word_prefix_filter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // prediction
  // --------------------------------------------------------------------------

  // keypad key of a letter code; end marker and codes past z have none
  function automatic logic [DIGIT_W-1:0] keypad_key(input letter_t code);
    case (code)
      5'd1, 5'd2:                      keypad_key = 4'd0;
      5'd3, 5'd4:                      keypad_key = 4'd1;
      5'd5, 5'd6:                      keypad_key = 4'd2;
      5'd7, 5'd8, 5'd9:                keypad_key = 4'd3;
      5'd10, 5'd11, 5'd12, 5'd13:      keypad_key = 4'd4;
      5'd14, 5'd15, 5'd16:             keypad_key = 4'd5;
      5'd17, 5'd18:                    keypad_key = 4'd6;
      5'd19:                           keypad_key = 4'd7;
      5'd20, 5'd21:                    keypad_key = 4'd8;
      5'd22, 5'd23, 5'd24, 5'd25, 5'd26: keypad_key = 4'd9;
      default:                         keypad_key = NO_GROUP;
    endcase
  endfunction

  function automatic spelling_t letters_of(input kwpf_in_t w);
    spelling_t lt;
    lt[0] = w.letter_0;
    lt[1] = w.letter_1;
    lt[2] = w.letter_2;
    lt[3] = w.letter_3;
    lt[4] = w.letter_4;
    lt[5] = w.letter_5;
    lt[6] = w.letter_6;
    lt[7] = w.letter_7;
    return lt;
  endfunction

  // match test, count and next-key mask for one accepted word
  function automatic void judge_word(input kwpf_in_t w);
    spelling_t      lt;
    int unsigned    word_len;
    int unsigned    p;
    logic           fits;
    logic [DIGIT_W-1:0] k;
    kwpf_out_t      v;
    lt = letters_of(w);
    if (w.first_word) begin
      tally     = '0;
      next_keys = '0;
    end
    // the word ends at the first zero code, later letters do not count
    word_len = MAX_LETTERS;
    for (p = 0; p < MAX_LETTERS; p++)
      if (lt[p] == '0 && word_len == MAX_LETTERS) word_len = p;
    // every typed key needs a letter in its group at the same position
    fits = 1'b1;
    for (p = 0; p < q_len && fits; p++) begin
      if (p >= word_len) fits = 1'b0;
      else if (keypad_key(lt[p]) != q_digits[4*p +: 4]) fits = 1'b0;
    end
    if (fits) begin
      if (tally != COUNT_MAX) tally++;
      // letter right after the prefix, if the word is longer than it
      if (q_len < word_len) begin
        k = keypad_key(lt[q_len]);
        if (k < NUM_DIGITS) next_keys[k] = 1'b1;
      end
    end
    v.matched         = fits;
    v.match_index     = fits ? w.word_index : '0;
    v.match_total     = tally;
    v.next_digit_mask = next_keys;
    pending_verdicts.push_back(v);
  endfunction

  // --------------------------------------------------------------------------
  // result checking
  // --------------------------------------------------------------------------

  function automatic string show(input kwpf_out_t r);
    return $sformatf("matched=%0b index=%0d total=%0d mask=%b",
                     r.matched, r.match_index, r.match_total, r.next_digit_mask);
  endfunction

  function automatic void note_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) $display("error: %s", msg);
  endfunction

  function automatic void check_result(input kwpf_out_t got);
    kwpf_out_t want;
    results_seen++;
    if (pending_verdicts.size() == 0) begin
      note_fault({"result with no word outstanding: ", show(got)});
    end else begin
      want = pending_verdicts.pop_front();
      if (want.matched) matches_seen++;
      if (got.matched !== want.matched || got.match_index !== want.match_index ||
          got.match_total !== want.match_total ||
          got.next_digit_mask !== want.next_digit_mask)
        note_fault($sformatf("result %0d\n  expected %s\n  actual   %s",
                             results_seen, show(want), show(got)));
    end
  endfunction

  // receiver: checks each result transfer and decides out_ready for the
  // next cycle; a hold-off request keeps it low for a fixed stretch
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1)
      check_result(out_data);
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (steady) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // watchdog: any stretch with no transfer on either channel this long is
  // a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) === 1'b1 || (out_valid && out_ready) === 1'b1)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, pending_verdicts.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  function automatic kwpf_in_t pack_word(input logic first, input logic [INDEX_W-1:0] idx,
                                         input spelling_t lt);
    kwpf_in_t w;
    w.first_word = first;
    w.word_index = idx;
    w.letter_0   = lt[0];
    w.letter_1   = lt[1];
    w.letter_2   = lt[2];
    w.letter_3   = lt[3];
    w.letter_4   = lt[4];
    w.letter_5   = lt[5];
    w.letter_6   = lt[6];
    w.letter_7   = lt[7];
    return w;
  endfunction

  // lower case text to letter codes; a backquote gives the end marker and
  // the characters after z give codes 27 and up
  function automatic kwpf_in_t spell(input logic first, input logic [INDEX_W-1:0] idx,
                                     input string text);
    spelling_t lt;
    int        i;
    lt = '0;
    for (i = 0; i < text.len() && i < MAX_LETTERS; i++)
      lt[i] = LETTER_W'(int'(text[i]) - 96);
    return pack_word(first, idx, lt);
  endfunction

  // mostly real letters, now and then a code past z
  function automatic letter_t any_letter();
    if ($urandom_range(99) < 88) return letter_t'($urandom_range(1, 26));
    return letter_t'($urandom_range(27, 31));
  endfunction

  function automatic letter_t letter_for_key(input logic [DIGIT_W-1:0] k);
    letter_t c;
    if (k >= NUM_DIGITS) return any_letter();
    do c = letter_t'($urandom_range(1, 26)); while (keypad_key(c) != k);
    return c;
  endfunction

  // a dictionary word for the current query: most fit the prefix, some
  // have one bad letter inside it, the rest are noise
  function automatic kwpf_in_t dictionary_word(input logic first);
    spelling_t   lt;
    int unsigned kind, wlen, p, bad;
    kind = $urandom_range(99);
    if (q_len <= MAX_LETTERS && kind < 85) wlen = $urandom_range(q_len, MAX_LETTERS);
    else wlen = $urandom_range(0, MAX_LETTERS);
    for (p = 0; p < MAX_LETTERS; p++) begin
      if (p < wlen)
        lt[p] = (kind < 85 && p < q_len) ? letter_for_key(q_digits[4*p +: 4]) : any_letter();
      else if (p == wlen)
        lt[p] = '0;
      else
        lt[p] = letter_t'($urandom_range(0, 31));  // junk after the end marker
    end
    if (kind >= 70 && kind < 85 && q_len != 0 && q_len <= MAX_LETTERS) begin
      bad     = $urandom_range(0, q_len - 1);
      lt[bad] = any_letter();
    end
    return pack_word(first, INDEX_W'($urandom_range(0, 2047)), lt);
  endfunction

  // one word transfer, with random idle cycles in front of it
  task automatic send_word(input kwpf_in_t w);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    judge_word(w);
    items_sent++;
  endtask

  // stop offering words until every outstanding result is back, then let
  // the pipeline settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (2 * RESULT_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      CFG_QUERY_DIGITS: q_digits = data;
      CFG_QUERY_LENGTH: q_len    = data[QLEN_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // new key sequence, only with the block idle
  task automatic set_query(input logic [CFG_DATA_W-1:0] digits,
                           input logic [CFG_DATA_W-1:0] len_word);
    drain_results();
    write_reg(CFG_QUERY_DIGITS, digits);
    write_reg(CFG_QUERY_LENGTH, len_word);
    settings_used++;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // registers still at reset: empty query, every word matches
  task automatic test_empty_query_after_reset();
    spelling_t lt;
    send_word(spell(1'b1, 11'd0, "a"));
    send_word(spell(1'b0, 11'd2047, "zzzzzzzz"));
    send_word(spell(1'b0, 11'd1, ""));                 // empty word
    send_word(spell(1'b0, 11'd1024, "{bc"));           // code past z up front
    lt = {MAX_LETTERS{5'd31}};
    send_word(pack_word(1'b0, 11'd1023, lt));          // nothing but codes past z
    send_word(spell(1'b0, 11'd42, "s"));
  endtask

  // key sequence 3 5 4 2, as typed for "home"; upper nibbles are junk
  task automatic test_prefix_match();
    set_query(32'hFFFF_2453, 32'd4);
    send_word(spell(1'b1, 11'd10, "home"));            // prefix is the whole word
    send_word(spell(1'b0, 11'd11, "homes"));
    send_word(spell(1'b0, 11'd12, "gold"));
    send_word(spell(1'b0, 11'd13, "hom"));             // too short
    send_word(spell(1'b0, 11'd14, "home`s"));          // letters after end ignored
    send_word(spell(1'b0, 11'd15, "ho{e"));            // code past z inside prefix
    send_word(spell(1'b0, 11'd16, "inland"));
    send_word(spell(1'b0, 11'd17, "homer"));
    send_word(spell(1'b1, 11'd18, "gone"));            // new search, first is a miss
    send_word(spell(1'b0, 11'd19, "ihmfz"));
  endtask

  task automatic test_query_extremes();
    // every key out of range: no real letter fits
    set_query(32'hFFFF_FFFF, 32'd8);
    send_word(spell(1'b1, 11'h555, "zzzzzzzz"));
    // full length query over eight letters
    set_query(32'h9999_9999, 32'd8);
    send_word(spell(1'b1, 11'h2AA, "zyxwvzyx"));
    send_word(spell(1'b0, 11'h2AB, "vwxyzvw"));
    // longer than any word, with junk in the upper length bits
    set_query(32'h0000_0000, 32'hFFFF_FFF9);
    send_word(spell(1'b1, 11'd100, "abababab"));
    set_query(32'h0000_0000, 32'h0000_000F);
    send_word(spell(1'b0, 11'd101, "aaaaaaaa"));
    // writes to indexes without a register must change nothing
    set_query(32'h0000_0008, 32'd1);
    write_reg(CFG_SPARE_2, '1);
    write_reg(CFG_SPARE_3, '1);
    send_word(spell(1'b1, 11'd200, "tub"));
    send_word(spell(1'b0, 11'd201, "sun"));
  endtask

  // random queries, each searched by a batch of mostly fitting words
  task automatic test_random_search();
    int unsigned        phase, i, p, r;
    logic [QLEN_W-1:0]  qlen;
    logic [CFG_DATA_W-1:0] digits;
    for (phase = 0; phase < 12; phase++) begin
      r = $urandom_range(99);
      if (r < 70) qlen = QLEN_W'($urandom_range(0, 4));
      else if (r < 90) qlen = QLEN_W'($urandom_range(5, 8));
      else qlen = QLEN_W'($urandom_range(9, 15));
      digits = $urandom();
      for (p = 0; p < MAX_LETTERS; p++)
        if (p < qlen) digits[4*p +: 4] = DIGIT_W'($urandom_range(0, 9));
      // now and then a key without a letter group inside the prefix
      if (qlen != 0 && $urandom_range(9) == 0) begin
        p = $urandom_range(0, (qlen > MAX_LETTERS ? MAX_LETTERS : qlen) - 1);
        digits[4*p +: 4] = DIGIT_W'($urandom_range(10, 15));
      end
      set_query(digits, ($urandom() & 32'hFFFF_FFF0) | CFG_DATA_W'(qlen));
      // one phase runs with no idle cycles on either side
      steady <= (phase == 3);
      for (i = 0; i < 90; i++) begin
        if (phase == 7 && i == 40) hold_requests <= hold_requests + 1;
        if (phase == 5 && i == 60) drain_results();
        send_word(dictionary_word(i == 0 || $urandom_range(99) < 4));
      end
    end
  endtask

  // receiver holds off while words keep coming: the block fills and must
  // stall its input without losing or repeating a word
  task automatic test_backpressure();
    int unsigned i;
    set_query(32'h0000_0013, 32'd2);
    steady        <= 1'b1;
    hold_requests <= hold_requests + 1;
    for (i = 0; i < 40; i++)
      send_word(dictionary_word(i == 0));
    drain_results();
    steady <= 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_query_after_reset();
    test_prefix_match();
    test_query_extremes();
    test_random_search();
    test_backpressure();
    drain_results();
    repeat (4 * RESULT_LATENCY) @(posedge clk);
    $display("run covered %0d words under %0d key sequences, %0d of them matches,",
             items_sent, settings_used, matches_seen);
    $display("random idling, a %0d cycle receiver hold-off; %0d checks failed",
             HOLD_CYCLES, fault_count);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
